// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the shadow call stack.
// Depends on nothing; included by bscs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BSCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("port property violated");

// Condition that must never be seen at a clock edge outside reset.
`define BSCS_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden port condition seen");

`endif

// ===== rtl/bscs_pkg.sv =====
// Shared types, constants and helpers for the branch-trace shadow call stack.
// Depends on nothing; used by the stack memory, the top level and the checker.
`default_nettype none

package bscs_pkg;

    localparam int DEPTH     = 1024;
    localparam int CHAIN_MAX = 64;

    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int XLEN      = 64;
    localparam int LEN_W     = 8;
    localparam int KIND_W    = 3;
    localparam int DEPTH_W   = 11;
    localparam int LIMIT_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [XLEN-1:0]    KERN_BASE_RST    = 64'h8000_0000_0000_0000;
    localparam logic [LIMIT_W-1:0] CHAIN_LIMIT_RST  = 7'd64;
    localparam logic [LIMIT_W-1:0] CHAIN_MAX_L      = LIMIT_W'(CHAIN_MAX);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERN_BASE    = 1'b0,
        CFG_CHAIN_LIMIT  = 1'b1
    } cfg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE     = 3'd0,
        KIND_OVERFLOW = 3'd1,
        KIND_USER     = 3'd2,
        KIND_KERNEL   = 3'd3,
        KIND_ADDR     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DROP,
        ST_CHAIN_IP,
        ST_CHAIN_CMP,
        ST_CHAIN_ADDR,
        ST_CHAIN_END
    } state_t;

    typedef struct packed {
        logic            mark;
        logic [XLEN-1:0] addr;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    function automatic kind_t context_of(input logic [XLEN-1:0] addr,
                                         input logic [XLEN-1:0] kern_base);
        return (addr < kern_base) ? KIND_USER : KIND_KERNEL;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bscs_stack_mem.sv =====
// Stack storage: one write port and one registered read port, with read data in the cycle after the request.
// Depends on bscs_pkg for the entry layout and the request struct.
`default_nettype none

module bscs_stack_mem (
    input  wire logic              clk,
    input  wire bscs_pkg::mem_req_t req,
    output bscs_pkg::entry_t        rd_data
);

    bscs_pkg::entry_t mem [bscs_pkg::DEPTH];
    bscs_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/branch_trace_shadow_call_stack.sv =====
// Shadow call stack rebuilt from branch-trace events, top level.
// Depends on bscs_pkg and instantiates bscs_stack_mem.
//
// A word is taken when start is high and busy is low. Every word yields
// results on result_valid, one per cycle, each shown for a single cycle with
// no way to hold it off; last marks the final result of a word. A call, a
// plain branch, a return that has nothing to search and a callchain read
// with a limit below two are answered straight from idle. A return reads
// and compares stack entries from the top down until it finds its target
// or reaches the bottom. A trace begin does the same, then pops end-marked
// entries until an unmarked entry or the bottom of the stack stops it. A
// callchain read walks the stack from the top. The searches use the single
// read port of the stack memory, which delivers one entry per cycle.
`default_nettype none

module branch_trace_shadow_call_stack (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bscs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bscs_pkg::XLEN-1:0]         cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              action,
    input  wire logic [bscs_pkg::XLEN-1:0]         from_ip,
    input  wire logic [bscs_pkg::XLEN-1:0]         to_ip,
    input  wire logic [bscs_pkg::LEN_W-1:0]        branch_len,
    input  wire logic [bscs_pkg::XLEN-1:0]         trace_number,
    input  wire logic                              call_flag,
    input  wire logic                              return_flag,
    input  wire logic                              trace_begin_flag,
    input  wire logic                              trace_end_flag,
    output logic                                   result_valid,
    output logic [bscs_pkg::KIND_W-1:0]            entry_kind,
    output logic [bscs_pkg::XLEN-1:0]              entry_value,
    output logic                                   last,
    output logic [bscs_pkg::DEPTH_W-1:0]           depth
);

    localparam int ADDR_W  = bscs_pkg::ADDR_W;
    localparam int CNT_W   = bscs_pkg::CNT_W;
    localparam int XLEN    = bscs_pkg::XLEN;
    localparam int LIMIT_W = bscs_pkg::LIMIT_W;

    bscs_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [XLEN-1:0]    trace_reg, trace_next;
    logic [XLEN-1:0]    kern_base_reg;
    logic [LIMIT_W-1:0] chain_limit_reg;

    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [XLEN-1:0]    target_reg, target_next;
    logic               begin_reg, begin_next;
    logic [LIMIT_W-1:0] sz_reg, sz_next;
    logic [LIMIT_W-1:0] slot_reg, slot_next;
    bscs_pkg::kind_t    last_ctx_reg, last_ctx_next;
    logic [XLEN-1:0]    ip_reg, ip_next;
    bscs_pkg::kind_t    pend_kind_reg, pend_kind_next;
    logic [XLEN-1:0]    pend_value_reg, pend_value_next;

    logic               out_valid_reg, out_valid_next;
    bscs_pkg::kind_t    out_kind_reg, out_kind_next;
    logic [XLEN-1:0]    out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    bscs_pkg::mem_req_t mem_req;
    bscs_pkg::entry_t   rd_data;

    logic [CNT_W-1:0]   cnt_eff;
    logic [CNT_W-1:0]   new_cnt;
    logic [XLEN-1:0]    link_addr;
    logic               stack_full;
    logic [LIMIT_W-1:0] sz_in;
    logic [LIMIT_W-1:0] slot_inc;
    bscs_pkg::kind_t    rd_ctx;
    logic               search_end;

    bscs_stack_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kern_base_reg   <= bscs_pkg::KERN_BASE_RST;
            chain_limit_reg <= bscs_pkg::CHAIN_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (bscs_pkg::cfg_idx_t'(cfg_index))
                bscs_pkg::CFG_KERN_BASE:   kern_base_reg   <= cfg_data;
                bscs_pkg::CFG_CHAIN_LIMIT: chain_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bscs_pkg::ST_IDLE;
            count_reg     <= '0;
            trace_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            trace_reg     <= trace_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        target_reg     <= target_next;
        begin_reg      <= begin_next;
        sz_reg         <= sz_next;
        slot_reg       <= slot_next;
        last_ctx_reg   <= last_ctx_next;
        ip_reg         <= ip_next;
        pend_kind_reg  <= pend_kind_next;
        pend_value_reg <= pend_value_next;
        out_kind_reg   <= out_kind_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        cnt_eff = ((trace_number != trace_reg) && (trace_reg != '0)) ? '0 : count_reg;
        link_addr = from_ip + XLEN'(branch_len);
        stack_full = (cnt_eff == CNT_W'(bscs_pkg::DEPTH));
        sz_in = (chain_limit_reg > bscs_pkg::CHAIN_MAX_L) ? bscs_pkg::CHAIN_MAX_L
                                                           : chain_limit_reg;
        slot_inc = slot_reg + LIMIT_W'(1);
        rd_ctx = bscs_pkg::context_of(rd_data.addr, kern_base_reg);
        search_end = (rd_data.addr == target_reg) || (idx_reg == '0);
        new_cnt = (rd_data.addr == target_reg) ? CNT_W'(idx_reg) : count_reg;

        state_next      = state_reg;
        count_next      = count_reg;
        trace_next      = trace_reg;
        idx_next        = idx_reg;
        target_next     = target_reg;
        begin_next      = begin_reg;
        sz_next         = sz_reg;
        slot_next       = slot_reg;
        last_ctx_next   = last_ctx_reg;
        ip_next         = ip_reg;
        pend_kind_next  = pend_kind_reg;
        pend_value_next = pend_value_reg;
        out_valid_next  = 1'b0;
        out_kind_next   = out_kind_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        mem_req         = '0;

        case (state_reg)
            bscs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (!action)
                    begin
                        trace_next     = trace_number;
                        count_next     = cnt_eff;
                        out_valid_next = 1'b1;
                        out_kind_next  = bscs_pkg::KIND_DONE;
                        out_value_next = '0;
                        out_last_next  = 1'b1;
                        if (call_flag)
                        begin
                            if ((to_ip != '0) && (link_addr != to_ip))
                            begin
                                mem_req.wr_en        = 1'b1;
                                mem_req.wr_addr      = stack_full ? '0 : cnt_eff[ADDR_W-1:0];
                                mem_req.wr_data.addr = link_addr;
                                mem_req.wr_data.mark = trace_end_flag;
                                count_next = stack_full ? CNT_W'(1) : cnt_eff + CNT_W'(1);
                                if (stack_full)
                                begin
                                    out_kind_next = bscs_pkg::KIND_OVERFLOW;
                                end
                            end
                        end
                        else if ((trace_begin_flag || (return_flag && (from_ip != '0)))
                                 && (cnt_eff != '0))
                        begin
                            out_valid_next  = 1'b0;
                            idx_next        = ADDR_W'(cnt_eff - CNT_W'(1));
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = ADDR_W'(cnt_eff - CNT_W'(1));
                            target_next     = to_ip;
                            begin_next      = trace_begin_flag;
                            state_next      = bscs_pkg::ST_SEARCH;
                        end
                    end
                    else if (sz_in < LIMIT_W'(2))
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = bscs_pkg::KIND_DONE;
                        out_value_next = '0;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        pend_kind_next  = bscs_pkg::context_of(from_ip, kern_base_reg);
                        pend_value_next = '0;
                        last_ctx_next   = bscs_pkg::context_of(from_ip, kern_base_reg);
                        ip_next         = from_ip;
                        sz_next         = sz_in;
                        state_next      = bscs_pkg::ST_CHAIN_IP;
                    end
                end
            end

            bscs_pkg::ST_SEARCH:
            begin
                if (search_end)
                begin
                    count_next = new_cnt;
                    if (begin_reg && (new_cnt != '0))
                    begin
                        idx_next        = ADDR_W'(new_cnt - CNT_W'(1));
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ADDR_W'(new_cnt - CNT_W'(1));
                        state_next      = bscs_pkg::ST_DROP;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = bscs_pkg::KIND_DONE;
                        out_value_next = '0;
                        out_last_next  = 1'b1;
                        state_next     = bscs_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    idx_next        = idx_reg - ADDR_W'(1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg - ADDR_W'(1);
                end
            end

            bscs_pkg::ST_DROP:
            begin
                if (rd_data.mark && (idx_reg != '0))
                begin
                    count_next      = CNT_W'(idx_reg);
                    idx_next        = idx_reg - ADDR_W'(1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg - ADDR_W'(1);
                end
                else
                begin
                    if (rd_data.mark)
                    begin
                        count_next = CNT_W'(idx_reg);
                    end
                    out_valid_next = 1'b1;
                    out_kind_next  = bscs_pkg::KIND_DONE;
                    out_value_next = '0;
                    out_last_next  = 1'b1;
                    state_next     = bscs_pkg::ST_IDLE;
                end
            end

            bscs_pkg::ST_CHAIN_IP:
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = pend_kind_reg;
                out_value_next  = pend_value_reg;
                out_last_next   = 1'b0;
                pend_kind_next  = bscs_pkg::KIND_ADDR;
                pend_value_next = ip_reg;
                slot_next       = LIMIT_W'(2);
                if ((LIMIT_W'(2) < sz_reg) && (count_reg != '0))
                begin
                    idx_next        = ADDR_W'(count_reg - CNT_W'(1));
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ADDR_W'(count_reg - CNT_W'(1));
                    state_next      = bscs_pkg::ST_CHAIN_CMP;
                end
                else
                begin
                    state_next = bscs_pkg::ST_CHAIN_END;
                end
            end

            bscs_pkg::ST_CHAIN_CMP:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = pend_kind_reg;
                out_value_next = pend_value_reg;
                out_last_next  = 1'b0;
                if (rd_ctx != last_ctx_reg)
                begin
                    if (slot_reg >= (sz_reg - LIMIT_W'(1)))
                    begin
                        out_last_next = 1'b1;
                        state_next    = bscs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pend_kind_next  = rd_ctx;
                        pend_value_next = '0;
                        slot_next       = slot_inc;
                        last_ctx_next   = rd_ctx;
                        state_next      = bscs_pkg::ST_CHAIN_ADDR;
                    end
                end
                else
                begin
                    pend_kind_next  = bscs_pkg::KIND_ADDR;
                    pend_value_next = rd_data.addr;
                    slot_next       = slot_inc;
                    if ((slot_inc < sz_reg) && (idx_reg != '0))
                    begin
                        idx_next        = idx_reg - ADDR_W'(1);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_reg - ADDR_W'(1);
                    end
                    else
                    begin
                        state_next = bscs_pkg::ST_CHAIN_END;
                    end
                end
            end

            bscs_pkg::ST_CHAIN_ADDR:
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = pend_kind_reg;
                out_value_next  = pend_value_reg;
                out_last_next   = 1'b0;
                pend_kind_next  = bscs_pkg::KIND_ADDR;
                pend_value_next = rd_data.addr;
                slot_next       = slot_inc;
                if ((slot_inc < sz_reg) && (idx_reg != '0))
                begin
                    idx_next        = idx_reg - ADDR_W'(1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg - ADDR_W'(1);
                    state_next      = bscs_pkg::ST_CHAIN_CMP;
                end
                else
                begin
                    state_next = bscs_pkg::ST_CHAIN_END;
                end
            end

            bscs_pkg::ST_CHAIN_END:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = pend_kind_reg;
                out_value_next = pend_value_reg;
                out_last_next  = 1'b1;
                state_next     = bscs_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = bscs_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != bscs_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign entry_kind   = out_kind_reg;
    assign entry_value  = out_value_reg;
    assign last         = out_last_reg;
    assign depth        = bscs_pkg::DEPTH_W'(count_reg);

endmodule

`default_nettype wire

// ===== rtl/bscs_checker.sv =====
// Port-level checks on the shadow call stack, bound to the top level.
// Depends on bscs_pkg and the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bscs_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           busy,
    input wire logic                           result_valid,
    input wire logic [bscs_pkg::KIND_W-1:0]    entry_kind,
    input wire logic [bscs_pkg::XLEN-1:0]      entry_value,
    input wire logic                           last,
    input wire logic [bscs_pkg::DEPTH_W-1:0]   depth
);

    // Chains run unbroken at fixed depth while busy; status kinds only come last.
    `BSCS_ASSERT(a_chain_contiguous, clk, rst_n, result_valid && !last |=> result_valid)
    `BSCS_ASSERT(a_chain_depth_stable, clk, rst_n, result_valid && !last |=> $stable(depth))
    `BSCS_ASSERT(a_chain_keeps_busy, clk, rst_n, result_valid && !last |-> busy)
    `BSCS_NEVER(a_value_only_on_addr, clk, rst_n, result_valid && (entry_kind != bscs_pkg::KIND_ADDR) && (entry_value != '0))
    `BSCS_NEVER(a_status_is_final, clk, rst_n, result_valid && !last && ((entry_kind == bscs_pkg::KIND_DONE) || (entry_kind == bscs_pkg::KIND_OVERFLOW)))

endmodule

bind branch_trace_shadow_call_stack bscs_checker u_bscs_checker (.*);

`default_nettype wire

// ===== sim/tb_branch_trace_shadow_call_stack.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for branch_trace_shadow_call_stack: a queue-fed driver, a
// result monitor and a shadow-stack predictor. Depends on bscs_pkg and the block's RTL.
module tb_branch_trace_shadow_call_stack;

    localparam int XLEN      = bscs_pkg::XLEN;
    localparam int LEN_W     = bscs_pkg::LEN_W;
    localparam int KIND_W    = bscs_pkg::KIND_W;
    localparam int DEPTH_W   = bscs_pkg::DEPTH_W;
    localparam int LIMIT_W   = bscs_pkg::LIMIT_W;
    localparam int CFG_IDX_W = bscs_pkg::CFG_IDX_W;
    localparam int DEPTH     = bscs_pkg::DEPTH;
    localparam int CHAIN_MAX = bscs_pkg::CHAIN_MAX;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int LIMIT_STEPS [5] = '{0, 1, 2, 4, 127};
    localparam logic [XLEN-1:0] PROBE_IP = 64'h0000_0000_0041_0000;
    localparam logic [XLEN-1:0] K1 = 64'hffff_ffff_8100_0000;

    typedef struct {
        logic             action;
        logic [XLEN-1:0]  src;
        logic [XLEN-1:0]  dst;
        logic [LEN_W-1:0] len;
        logic [XLEN-1:0]  trace;
        logic             call;
        logic             ret;
        logic             restart;
        logic             ends;
    } trace_word_t;

    typedef struct {
        bscs_pkg::kind_t    kind;
        logic [XLEN-1:0]    value;
        logic               last;
        logic [DEPTH_W-1:0] depth;
    } chain_entry_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [XLEN-1:0]      cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 action = 1'b0;
    logic [XLEN-1:0]      from_ip = '0;
    logic [XLEN-1:0]      to_ip = '0;
    logic [LEN_W-1:0]     branch_len = '0;
    logic [XLEN-1:0]      trace_number = '0;
    logic                 call_flag = 1'b0;
    logic                 return_flag = 1'b0;
    logic                 trace_begin_flag = 1'b0;
    logic                 trace_end_flag = 1'b0;
    logic                 result_valid;
    logic [KIND_W-1:0]    entry_kind;
    logic [XLEN-1:0]      entry_value;
    logic                 last;
    logic [DEPTH_W-1:0]   depth;

    logic [XLEN-1:0]    stack_addr [DEPTH];
    logic               stack_mark [DEPTH];
    int                 stack_top = 0;
    logic [XLEN-1:0]    last_trace = '0;
    logic [XLEN-1:0]    kern_base = bscs_pkg::KERN_BASE_RST;
    logic [LIMIT_W-1:0] chain_cap = bscs_pkg::CHAIN_LIMIT_RST;

    trace_word_t     trace_words [$];
    chain_entry_t    awaited_entries [$];
    logic [XLEN-1:0] gen_addr [$];
    logic            gen_mark [$];
    logic [XLEN-1:0] gen_trace;

    trace_word_t  in_word;
    chain_entry_t seen_entry;
    int           idle_left = 0;
    logic         steady = 1'b0;
    int           mismatches = 0;
    int           cycle_count = 0;

    branch_trace_shadow_call_stack dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string field, input logic [XLEN-1:0] got,
                                   input logic [XLEN-1:0] want);
        $display("mismatch on %s: got %h, want %h", field, got, want);
        mismatches++;
    endtask

    function automatic bscs_pkg::kind_t addr_context(input logic [XLEN-1:0] addr);
        if (addr >= kern_base)
            return bscs_pkg::KIND_KERNEL;
        return bscs_pkg::KIND_USER;
    endfunction

    function automatic void expect_entry(input bscs_pkg::kind_t kind,
                                         input logic [XLEN-1:0] value, input logic fin);
        chain_entry_t e;
        e.kind = kind;
        e.value = value;
        e.last = fin;
        e.depth = DEPTH_W'(stack_top);
        awaited_entries.push_back(e);
    endfunction

    function automatic void cut_stack(input logic [XLEN-1:0] target);
        for (int i = stack_top - 1; i >= 0; i--)
        begin
            if (stack_addr[i] == target)
            begin
                stack_top = i;
                break;
            end
        end
    endfunction

    function automatic void advance_stack(input trace_word_t w);
        logic [XLEN-1:0] link_addr;
        logic            spilled;
        int              cap;
        int              slot;
        int              walk;
        bscs_pkg::kind_t ctx;
        bscs_pkg::kind_t prev_ctx;
        chain_entry_t    tail;
        if (!w.action)
        begin
            spilled = 1'b0;
            if (w.trace != last_trace)
            begin
                if (last_trace != '0)
                    stack_top = 0;
                last_trace = w.trace;
            end
            if (w.call)
            begin
                link_addr = w.src + XLEN'(w.len);
                if (w.dst != '0 && link_addr != w.dst)
                begin
                    if (stack_top >= DEPTH)
                    begin
                        stack_top = 0;
                        spilled = 1'b1;
                    end
                    stack_addr[stack_top] = link_addr;
                    stack_mark[stack_top] = w.ends;
                    stack_top++;
                end
            end
            else if (w.restart)
            begin
                cut_stack(w.dst);
                while (stack_top > 0 && stack_mark[stack_top - 1])
                    stack_top--;
            end
            else if (w.ret && w.src != '0)
            begin
                cut_stack(w.dst);
            end
            expect_entry(spilled ? bscs_pkg::KIND_OVERFLOW : bscs_pkg::KIND_DONE, '0, 1'b1);
        end
        else
        begin
            cap = (int'(chain_cap) > CHAIN_MAX) ? CHAIN_MAX : int'(chain_cap);
            if (cap < 2)
            begin
                expect_entry(bscs_pkg::KIND_DONE, '0, 1'b1);
            end
            else
            begin
                prev_ctx = addr_context(w.src);
                expect_entry(prev_ctx, '0, 1'b0);
                expect_entry(bscs_pkg::KIND_ADDR, w.src, 1'b0);
                slot = 2;
                walk = 1;
                while (slot < cap && walk <= stack_top)
                begin
                    ctx = addr_context(stack_addr[stack_top - walk]);
                    if (ctx != prev_ctx)
                    begin
                        if (slot >= cap - 1)
                            break;
                        expect_entry(ctx, '0, 1'b0);
                        slot++;
                        prev_ctx = ctx;
                    end
                    expect_entry(bscs_pkg::KIND_ADDR, stack_addr[stack_top - walk], 1'b0);
                    slot++;
                    walk++;
                end
                tail = awaited_entries.pop_back();
                tail.last = 1'b1;
                awaited_entries.push_back(tail);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && (!start || !busy))
        begin
            if (start)
                advance_stack(in_word);
            if (idle_left == 0 && !steady && $urandom_range(0, 5) == 0)
                idle_left = $urandom_range(1, 13);
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (trace_words.size() != 0)
            begin
                in_word = trace_words.pop_front();
                start <= 1'b1;
                action <= in_word.action;
                from_ip <= in_word.src;
                to_ip <= in_word.dst;
                branch_len <= in_word.len;
                trace_number <= in_word.trace;
                call_flag <= in_word.call;
                return_flag <= in_word.ret;
                trace_begin_flag <= in_word.restart;
                trace_end_flag <= in_word.ends;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (awaited_entries.size() == 0)
            begin
                report_mismatch("unexpected result kind", XLEN'(entry_kind), '0);
            end
            else
            begin
                seen_entry = awaited_entries.pop_front();
                if (entry_kind !== seen_entry.kind)
                    report_mismatch("entry_kind", XLEN'(entry_kind), XLEN'(seen_entry.kind));
                if (entry_value !== seen_entry.value)
                    report_mismatch("entry_value", entry_value, seen_entry.value);
                if (last !== seen_entry.last)
                    report_mismatch("last", XLEN'(last), XLEN'(seen_entry.last));
                if (depth !== seen_entry.depth)
                    report_mismatch("depth", XLEN'(depth), XLEN'(seen_entry.depth));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [XLEN-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [XLEN-1:0] rand_addr();
        case ($urandom_range(0, 3))
            0: return {32'h0, $urandom};
            1: return {32'hffff_ffff, $urandom};
            2: return rand64();
            default: return kern_base + XLEN'($urandom_range(0, 3)) - XLEN'(2);
        endcase
    endfunction

    function automatic void queue_event(input logic [XLEN-1:0] src, input logic [XLEN-1:0] dst,
                                        input logic [LEN_W-1:0] len,
                                        input logic [XLEN-1:0] trace, input logic call,
                                        input logic ret, input logic restart,
                                        input logic ends);
        trace_word_t w;
        w.action = 1'b0;
        w.src = src;
        w.dst = dst;
        w.len = len;
        w.trace = trace;
        w.call = call;
        w.ret = ret;
        w.restart = restart;
        w.ends = ends;
        trace_words.push_back(w);
    endfunction

    function automatic void queue_read(input logic [XLEN-1:0] src);
        trace_word_t w;
        w.action = 1'b1;
        w.src = src;
        w.dst = rand64();
        w.len = LEN_W'($urandom);
        w.trace = rand64();
        w.call = 1'($urandom);
        w.ret = 1'($urandom);
        w.restart = 1'($urandom);
        w.ends = 1'($urandom);
        trace_words.push_back(w);
    endfunction

    task automatic settle();
        do
            @(negedge clk);
        while (trace_words.size() != 0 || start || busy || awaited_entries.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input bscs_pkg::cfg_idx_t idx, input logic [XLEN-1:0] data);
        settle();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == bscs_pkg::CFG_KERN_BASE)
            kern_base = data;
        else
            chain_cap = data[LIMIT_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int pick_frame();
        if (gen_addr.size() == 0 || $urandom_range(0, 5) == 0)
            return -1;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, gen_addr.size() - 1);
        return gen_addr.size() - 1;
    endfunction

    function automatic void trim_frames(input int idx);
        while (gen_addr.size() > idx)
        begin
            void'(gen_addr.pop_back());
            void'(gen_mark.pop_back());
        end
    endfunction

    function automatic void change_trace(input logic [XLEN-1:0] trace);
        if (trace != gen_trace)
        begin
            if (gen_trace != '0)
                trim_frames(0);
            gen_trace = trace;
        end
    endfunction

    task automatic random_words(input int n);
        logic [XLEN-1:0]  src;
        logic [XLEN-1:0]  dst;
        logic [XLEN-1:0]  trace;
        logic [LEN_W-1:0] len;
        logic             ends;
        int               pick;
        int               idx;
        gen_addr.delete();
        gen_mark.delete();
        for (int i = 0; i < stack_top; i++)
        begin
            gen_addr.push_back(stack_addr[i]);
            gen_mark.push_back(stack_mark[i]);
        end
        gen_trace = last_trace;
        if (gen_trace == '0)
            gen_trace = 64'h5;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                src = rand_addr();
                len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom)
                                                  : LEN_W'($urandom_range(1, 15));
                dst = rand_addr();
                if ($urandom_range(0, 19) == 0)
                    dst = '0;
                else if ($urandom_range(0, 19) == 0)
                    dst = src + XLEN'(len);
                ends = ($urandom_range(0, 5) == 0);
                if (dst != '0 && src + XLEN'(len) != dst)
                begin
                    if (gen_addr.size() >= DEPTH)
                        trim_frames(0);
                    gen_addr.push_back(src + XLEN'(len));
                    gen_mark.push_back(ends);
                end
                queue_event(src, dst, len, gen_trace, 1'b1, $urandom_range(0, 7) == 0,
                            $urandom_range(0, 7) == 0, ends);
            end
            else if (pick < 58)
            begin
                src = ($urandom_range(0, 15) == 0) ? '0 : rand_addr();
                idx = pick_frame();
                dst = (idx < 0) ? rand_addr() : gen_addr[idx];
                if (src != '0 && idx >= 0)
                    trim_frames(idx);
                queue_event(src, dst, LEN_W'($urandom), gen_trace, 1'b0, 1'b1, 1'b0,
                            1'($urandom));
            end
            else if (pick < 66)
            begin
                idx = pick_frame();
                dst = (idx < 0) ? rand_addr() : gen_addr[idx];
                if (idx >= 0)
                    trim_frames(idx);
                while (gen_addr.size() > 0 && gen_mark[gen_mark.size() - 1])
                    trim_frames(gen_addr.size() - 1);
                queue_event(rand_addr(), dst, LEN_W'($urandom), gen_trace, 1'b0,
                            1'($urandom), 1'b1, 1'($urandom));
            end
            else if (pick < 80)
            begin
                queue_read(rand_addr());
            end
            else if (pick < 88)
            begin
                trace = ($urandom_range(0, 3) == 0) ? '0 : rand64();
                change_trace(trace);
                queue_event(rand_addr(), rand_addr(), LEN_W'($urandom), trace, 1'b0, 1'b0,
                            1'b0, 1'b0);
            end
            else
            begin
                trace = ($urandom_range(0, 1) == 0) ? gen_trace : rand64();
                change_trace(trace);
                queue_event(rand64(), rand64(), LEN_W'($urandom), trace, 1'($urandom),
                            1'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [XLEN-1:0] noise;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_read(64'h0000_0000_0040_1000);
        queue_event(64'h401000, 64'h401040, 8'd2, 64'h1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(64'h401000, 64'h0, 8'd5, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_event(64'h401010, 64'h401015, 8'd5, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_event(64'h401100, 64'h402000, 8'd5, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_event(K1, K1 + 64'h1000, 8'd8, 64'h1, 1'b1, 1'b0, 1'b0, 1'b1);
        queue_event(64'hffff_ffff_ffff_ff80, 64'h1234, 8'd255, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_event(64'h403000, 64'h404800, 8'd3, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_read(K1 + 64'h55);
        queue_event(64'h0, 64'h403003, 8'd1, 64'h1, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_event(64'h500, 64'hdead, 8'd1, 64'h1, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_event(64'h600, 64'hfd, 8'd1, 64'h1, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_event(64'h404000, 64'h405000, 8'd4, 64'h1, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_event(64'h700, 64'h9999, 8'd1, 64'h1, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_event(K1 + 64'h200, K1 + 64'h5000, 8'd2, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_event(64'h408000, 64'h409999, 8'd6, 64'h1, 1'b1, 1'b0, 1'b0, 1'b1);
        queue_event(64'h800, 64'h408006, 8'd1, 64'h1, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_read(64'hffff_ffff_ffff_ffff);
        queue_event(64'h900, 64'ha00, 8'd2, 64'h2, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(64'h409000, 64'h40b000, 8'd2, 64'h2, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_event(K1 + 64'h300, K1 + 64'h6000, 8'd4, 64'h2, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_event(64'h40a000, 64'h40c000, 8'd1, 64'h2, 1'b1, 1'b0, 1'b0, 1'b0);

        foreach (LIMIT_STEPS[k])
        begin
            noise = rand64();
            write_reg(bscs_pkg::CFG_CHAIN_LIMIT,
                      {noise[XLEN-1:LIMIT_W], LIMIT_W'(LIMIT_STEPS[k])});
            queue_read(PROBE_IP);
        end
        write_reg(bscs_pkg::CFG_CHAIN_LIMIT, XLEN'(bscs_pkg::CHAIN_LIMIT_RST));
        write_reg(bscs_pkg::CFG_KERN_BASE, '0);
        queue_read(PROBE_IP);
        write_reg(bscs_pkg::CFG_KERN_BASE, '1);
        queue_read(PROBE_IP);

        write_reg(bscs_pkg::CFG_KERN_BASE, bscs_pkg::KERN_BASE_RST);
        queue_read(64'h0000_4000_1000_0000);
        queue_event(64'h10, 64'hdead_0000, 8'd1, 64'h77, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_event(64'h20, 64'hdead_0001, 8'd1, 64'h77, 1'b0, 1'b0, 1'b1, 1'b0);
        for (int i = 0; i < 4; i++)
            queue_event(64'h50_0000 + XLEN'(i * 16), 64'h60_0000, 8'd4, 64'h77, 1'b1, 1'b0,
                        1'b0, 1'b0);
        queue_read(64'hffff_8000_0000_0000);

        write_reg(bscs_pkg::CFG_KERN_BASE, rand64());
        write_reg(bscs_pkg::CFG_CHAIN_LIMIT, XLEN'($urandom_range(2, CHAIN_MAX)));
        random_words(18);
        write_reg(bscs_pkg::CFG_KERN_BASE, 64'hffff_ffff_0000_0000);
        write_reg(bscs_pkg::CFG_CHAIN_LIMIT, 64'd3);
        random_words(18);
        noise = rand64();
        write_reg(bscs_pkg::CFG_KERN_BASE, 64'h0000_0001_0000_0000);
        write_reg(bscs_pkg::CFG_CHAIN_LIMIT,
                  {noise[XLEN-1:LIMIT_W], LIMIT_W'($urandom_range(0, 127))});
        random_words(18);
        write_reg(bscs_pkg::CFG_KERN_BASE, bscs_pkg::KERN_BASE_RST);
        write_reg(bscs_pkg::CFG_CHAIN_LIMIT, XLEN'(bscs_pkg::CHAIN_LIMIT_RST));
        steady = 1'b1;
        random_words(18);

        settle();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
